// ----- design/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef logic [1:0] cause_t;
  localparam cause_t CAUSE_CTRL     = 2'd0;
  localparam cause_t CAUSE_ESC_CTRL = 2'd1;
  localparam cause_t CAUSE_BAD_ESC  = 2'd2;
  localparam cause_t CAUSE_BAD_HEX  = 2'd3;

  // One decoded command: a literal byte, a code point to encode, or a string end.
  typedef struct packed {
    logic        is_code;
    logic        string_end;
    cause_t      cause;
    logic [15:0] code;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

endpackage

// ----- design/jsu_front.sv -----
// Front end: escape-state tracking and classification of each input word.
module jsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  output jsu_pkg::cmd_slot_t push
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_PLAIN = 3'd0,
    M_ESC   = 3'd1,
    M_HEX0  = 3'd2,
    M_HEX1  = 3'd3,
    M_HEX2  = 3'd4,
    M_HEX3  = 3'd5
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [11:0] acc_r, acc_nxt;
  cmd_slot_t   slot;

  // Bit 4 flags a legal hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    return r;
  endfunction

  logic [4:0] hx;
  assign hx = hex_digit(in_byte);

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    slot     = '0;
    unique case (mode_r)
      M_ESC: begin
        mode_nxt = M_PLAIN;
        if (in_byte < 8'h20) begin
          slot.valid = 1'b1;
          slot.cmd.string_end = 1'b1;
          slot.cmd.cause = CAUSE_ESC_CTRL;
          acc_nxt = '0;
        end else if (in_byte == 8'h75) begin
          mode_nxt = M_HEX0;
          acc_nxt  = '0;
        end else begin
          slot.valid = 1'b1;
          unique case (in_byte)
            8'h62: slot.cmd.code = 16'h0008;
            8'h66: slot.cmd.code = 16'h000C;
            8'h6E: slot.cmd.code = 16'h000A;
            8'h72: slot.cmd.code = 16'h000D;
            8'h74: slot.cmd.code = 16'h0009;
            8'h22, 8'h5C, 8'h2F: slot.cmd.code = {8'h00, in_byte};
            default: begin
              slot.cmd.string_end = 1'b1;
              slot.cmd.cause = CAUSE_BAD_ESC;
              acc_nxt = '0;
            end
          endcase
        end
      end
      M_HEX0, M_HEX1, M_HEX2, M_HEX3: begin
        if (!hx[4]) begin
          mode_nxt = M_PLAIN;
          acc_nxt  = '0;
          slot.valid = 1'b1;
          slot.cmd.string_end = 1'b1;
          slot.cmd.cause = CAUSE_BAD_HEX;
        end else if (mode_r == M_HEX3) begin
          mode_nxt = M_PLAIN;
          acc_nxt  = '0;
          slot.valid = 1'b1;
          slot.cmd.is_code = 1'b1;
          slot.cmd.code = {acc_r, hx[3:0]};
        end else begin
          mode_nxt = mode_t'(mode_r + 3'd1);
          acc_nxt  = {acc_r[7:0], hx[3:0]};
        end
      end
      default: begin
        // plain text; unused mode codes fall in here too
        mode_nxt = M_PLAIN;
        if (in_byte < 8'h20) begin
          slot.valid = 1'b1;
          slot.cmd.string_end = 1'b1;
          slot.cmd.cause = CAUSE_CTRL;
          acc_nxt = '0;
        end else if (in_byte == 8'h5C) begin
          mode_nxt = M_ESC;
        end else begin
          slot.valid = 1'b1;
          slot.cmd.code = {8'h00, in_byte};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      acc_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_comb begin
    push       = slot;
    push.valid = slot.valid & accept;
  end

endmodule

// ----- design/jsu_queue.sv -----
// Command queue between front end and encoder.
module jsu_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  jsu_pkg::cmd_slot_t push,
  input  logic               pop,
  output jsu_pkg::cmd_slot_t head,
  output logic               full
);
  import jsu_pkg::*;

  cmd_t           mem [QDepth];
  logic [QAw-1:0] wr_r, rd_r;
  logic [QAw:0]   cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (QAw+1)'(QDepth));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push.cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (QAw+1)'(do_push) - (QAw+1)'(do_pop);
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = mem[rd_r];

endmodule

// ----- design/jsu_back.sv -----
// Back end: UTF-8 encoding and the output register.
module jsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jsu_pkg::cmd_slot_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               out_string_end,
  output jsu_pkg::cause_t    out_end_cause
);
  import jsu_pkg::*;

  logic [1:0] idx_r;
  logic [1:0] nbytes;
  logic [7:0] b0, b1, b2, sel;
  logic       load, is_last;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r, end_r;
  cause_t     cause_r;
  logic [15:0] c;

  assign c = head.cmd.code;

  always_comb begin
    if (!head.cmd.is_code || c <= 16'h007F) begin
      nbytes = 2'd1;
      b0 = c[7:0];
      b1 = 8'h00;
      b2 = 8'h00;
    end else if (c <= 16'h07FF) begin
      nbytes = 2'd2;
      b0 = 8'hC0 | {3'b000, c[10:6]};
      b1 = 8'h80 | {2'b00, c[5:0]};
      b2 = 8'h00;
    end else begin
      nbytes = 2'd3;
      b0 = 8'hE0 | {4'h0, c[15:12]};
      b1 = 8'h80 | {2'b00, c[11:6]};
      b2 = 8'h80 | {2'b00, c[5:0]};
    end
    unique case (idx_r)
      2'd0:    sel = b0;
      2'd1:    sel = b1;
      default: sel = b2;
    endcase
  end

  assign load    = head.valid && (!valid_r || !out_stall);
  assign is_last = (idx_r == nbytes - 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
      if (load) idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= sel;
      last_r  <= is_last;
      end_r   <= head.cmd.string_end;
      cause_r <= head.cmd.string_end ? head.cmd.cause : CAUSE_CTRL;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_last       = last_r;
  assign out_string_end = end_r;
  assign out_end_cause  = cause_r;

endmodule

// ----- design/json_string_unescape_utf8.sv -----
// Top level of the JSON string body unescaper with UTF-8 output.
//
// Input channel (in_valid / in_stall / in_byte): one byte of an escaped JSON
// string body per word. Output channel (out_valid / out_stall / out_byte,
// out_last, out_string_end, out_end_cause): one decoded UTF-8 byte per word.
// A word moves on a rising edge where valid is high and stall is low.
// Each input word yields zero results (backslash, \u prefix, hex digits one
// to three), one result, or one to three results (a \uXXXX code point).
// out_last marks the final result of an input word. An illegal byte yields
// one NUL word with out_string_end set and the cause in out_end_cause, and
// the decoder drops back to plain text for the next string.
// The first result of an input word shows on out_valid once it has passed
// the queue write and then the output register.
// Throughput: one input word per cycle while the queue has room and one output
// word per cycle while out_stall is low; the encoder emits the bytes of a code
// point in turn and holds the command queue head until its last byte is loaded.
// The four-entry command queue decouples the two sides: in_stall rises only
// when the queue is full, so a stalled receiver backs up through it.
// Reset (rst_n low, synchronous) empties the queue and output register and
// returns the decoder to plain text with an empty hex accumulator.
module json_string_unescape_utf8 (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output logic                 out_string_end,
  output jsu_pkg::cause_t      out_end_cause
);
  import jsu_pkg::*;

  cmd_slot_t push, head;
  logic      accept, pop, full;

  // accept a word whenever the queue has room
  assign in_stall = full;
  assign accept   = in_valid && !full;

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .push    (push)
  );

  jsu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (full)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_string_end (out_string_end),
    .out_end_cause  (out_end_cause)
  );

endmodule

// ----- design/jsu_checker.sv -----
// Port-level checks for the JSON string unescaper, bound to the top level.
module jsu_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input logic [7:0]      out_byte,
  input logic            out_last,
  input logic            out_string_end,
  input jsu_pkg::cause_t out_end_cause
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output word changed");

  // a string end is a lone NUL word
  a_end_nul: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_end |-> out_byte == 8'h00 && out_last)
    else $error("string end is not a single NUL");

  a_cause_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_string_end |-> out_end_cause == jsu_pkg::CAUSE_CTRL)
    else $error("cause set on a data byte");

  // only lead and continuation bytes of a multi-byte sequence are non-last
  a_multi_hi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_byte[7] && !out_string_end)
    else $error("non-last byte is not part of a UTF-8 sequence");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
